>>> sv/indexed_list_store_assert.svh
// assertion macros used by the list store top level
`ifndef INDEXED_LIST_STORE_ASSERT_SVH
`define INDEXED_LIST_STORE_ASSERT_SVH

// condition in this cycle implies a condition in the same cycle
`define ILS_ASSERT_SAME(name, clk, rst, pre, post, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
      else $error(msg);

// condition in this cycle implies a condition in the next cycle
`define ILS_ASSERT_NEXT(name, clk, rst, pre, post, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
      else $error(msg);

`endif

>>> sv/ils_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package ils_pkg;

   localparam int CAPACITY_DEF = 64;
   localparam int OP_W         = 3;
   localparam int POS_W        = 7;
   localparam int DATA_W       = 32;
   localparam int ST_W         = 2;
   localparam int CNT_OUT_W    = 7;

   // opcodes
   localparam logic [OP_W-1:0] OP_GET      = 3'd0;
   localparam logic [OP_W-1:0] OP_ADD_HEAD = 3'd1;
   localparam logic [OP_W-1:0] OP_ADD_TAIL = 3'd2;
   localparam logic [OP_W-1:0] OP_ADD_AT   = 3'd3;
   localparam logic [OP_W-1:0] OP_DELETE   = 3'd4;

   // status codes
   localparam logic [ST_W-1:0] ST_DONE  = 2'd0;
   localparam logic [ST_W-1:0] ST_RANGE = 2'd1;
   localparam logic [ST_W-1:0] ST_FULL  = 2'd2;

   localparam logic signed [DATA_W-1:0] NEG_ONE = -32'sd1;

   // one finished result
   typedef struct packed {
      logic signed [DATA_W-1:0] read_value;
      logic [ST_W-1:0]          status;
      logic [CNT_OUT_W-1:0]     entry_count;
   } res_type;

endpackage

`default_nettype wire

>>> sv/ils_ram.sv
`timescale 1ns / 1ps
`default_nettype none

module ils_ram #(
   parameter int DEPTH = ils_pkg::CAPACITY_DEF,
   parameter int AW    = 6,
   parameter int DW    = ils_pkg::DATA_W
) (
   input  wire logic          clock,
   input  wire logic          wr_en,
   input  wire logic [AW-1:0] wr_addr,
   input  wire logic [DW-1:0] wr_data,
   input  wire logic [AW-1:0] rd_addr,
   output logic      [DW-1:0] rd_data
);

   logic [DW-1:0] mem_ff [DEPTH];
   logic [DW-1:0] rd_data_ff;

   // single write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // registered read port
   always_ff @(posedge clock) begin
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

>>> sv/ils_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none

module ils_ctrl #(
   parameter int CAPACITY = ils_pkg::CAPACITY_DEF,
   parameter int AW       = 6
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            req_valid,
   output logic                                 req_ready,
   input  wire logic [ils_pkg::OP_W-1:0]        req_opcode,
   input  wire logic [ils_pkg::POS_W-1:0]       req_position,
   input  wire logic signed [ils_pkg::DATA_W-1:0] req_value,
   output logic                                 res_valid,
   input  wire logic                            res_take,
   output ils_pkg::res_type                     res,
   output logic                                 mem_wr_en,
   output logic [AW-1:0]                        mem_wr_addr,
   output logic [ils_pkg::DATA_W-1:0]           mem_wr_data,
   output logic [AW-1:0]                        mem_rd_addr,
   input  wire logic [ils_pkg::DATA_W-1:0]      mem_rd_data
);

   localparam int CW = $clog2(CAPACITY + 1);
   localparam int XW = (CW > ils_pkg::POS_W) ? CW : ils_pkg::POS_W;

   localparam logic [2:0] S_IDLE  = 3'd0;
   localparam logic [2:0] S_MOVE  = 3'd1;
   localparam logic [2:0] S_DRAIN = 3'd2;
   localparam logic [2:0] S_PLACE = 3'd3;
   localparam logic [2:0] S_GETW  = 3'd4;
   localparam logic [2:0] S_DONE  = 3'd5;

   logic [2:0]                       state_ff, state_in;
   logic [CW-1:0]                    count_ff, count_in;
   logic [AW-1:0]                    src_ff, src_in;
   logic [AW-1:0]                    last_ff, last_in;
   logic                             up_ff, up_in;
   logic                             ins_ff, ins_in;
   logic [AW-1:0]                    place_ff, place_in;
   logic [ils_pkg::DATA_W-1:0]       val_ff, val_in;
   logic                             pend_ff, pend_in;
   logic [AW-1:0]                    pend_addr_ff, pend_addr_in;
   logic signed [ils_pkg::DATA_W-1:0] rd_ff, rd_in;
   logic [ils_pkg::ST_W-1:0]         st_ff, st_in;

   logic [XW-1:0] pos_x;
   logic [XW-1:0] cnt_x;
   logic [XW-1:0] ipos_x;

   assign pos_x = XW'(req_position);
   assign cnt_x = XW'(count_ff);

   // sequencer and shared move index
   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      src_in       = src_ff;
      last_in      = last_ff;
      up_in        = up_ff;
      ins_in       = ins_ff;
      place_in     = place_ff;
      val_in       = val_ff;
      pend_in      = 1'b0;
      pend_addr_in = pend_addr_ff;
      rd_in        = rd_ff;
      st_in        = st_ff;
      ipos_x       = pos_x;
      mem_rd_addr  = src_ff;
      mem_wr_en    = pend_ff;
      mem_wr_addr  = pend_addr_ff;
      mem_wr_data  = mem_rd_data;

      case (state_ff)
         S_IDLE: begin
            mem_rd_addr = pos_x[AW-1:0];
            if (req_valid) begin
               rd_in    = '0;
               st_in    = ils_pkg::ST_DONE;
               state_in = S_DONE;
               case (req_opcode)
                  ils_pkg::OP_GET: begin
                     if (pos_x < cnt_x) begin
                        state_in = S_GETW;
                     end else begin
                        rd_in = ils_pkg::NEG_ONE;
                        st_in = ils_pkg::ST_RANGE;
                     end
                  end
                  ils_pkg::OP_ADD_HEAD, ils_pkg::OP_ADD_TAIL, ils_pkg::OP_ADD_AT: begin
                     if (req_opcode == ils_pkg::OP_ADD_HEAD) begin
                        ipos_x = '0;
                     end else if (req_opcode == ils_pkg::OP_ADD_TAIL) begin
                        ipos_x = cnt_x;
                     end
                     if (req_opcode == ils_pkg::OP_ADD_AT && pos_x > cnt_x) begin
                        st_in = ils_pkg::ST_RANGE;
                     end else if (count_ff == CW'(CAPACITY)) begin
                        st_in = ils_pkg::ST_FULL;
                     end else begin
                        count_in = count_ff + CW'(1);
                        val_in   = req_value;
                        place_in = ipos_x[AW-1:0];
                        ins_in   = 1'b1;
                        up_in    = 1'b1;
                        if (ipos_x == cnt_x) begin
                           state_in = S_PLACE;
                        end else begin
                           src_in   = AW'(cnt_x - XW'(1));
                           last_in  = ipos_x[AW-1:0];
                           state_in = S_MOVE;
                        end
                     end
                  end
                  ils_pkg::OP_DELETE: begin
                     if (pos_x >= cnt_x) begin
                        st_in = ils_pkg::ST_RANGE;
                     end else begin
                        count_in = count_ff - CW'(1);
                        ins_in   = 1'b0;
                        up_in    = 1'b0;
                        if (pos_x + XW'(1) != cnt_x) begin
                           src_in   = AW'(pos_x + XW'(1));
                           last_in  = AW'(cnt_x - XW'(1));
                           state_in = S_MOVE;
                        end
                     end
                  end
                  default: begin
                     st_in = ils_pkg::ST_RANGE;
                  end
               endcase
            end
         end
         S_MOVE: begin
            // read one entry now, write it one slot over next cycle
            pend_in      = 1'b1;
            pend_addr_in = up_ff ? (src_ff + AW'(1)) : (src_ff - AW'(1));
            if (src_ff == last_ff) begin
               state_in = S_DRAIN;
            end else begin
               src_in = up_ff ? (src_ff - AW'(1)) : (src_ff + AW'(1));
            end
         end
         S_DRAIN: begin
            state_in = ins_ff ? S_PLACE : S_DONE;
         end
         S_PLACE: begin
            mem_wr_en   = 1'b1;
            mem_wr_addr = place_ff;
            mem_wr_data = val_ff;
            state_in    = S_DONE;
         end
         S_GETW: begin
            rd_in    = mem_rd_data;
            state_in = S_DONE;
         end
         S_DONE: begin
            if (res_take) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         count_ff <= '0;
         pend_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         pend_ff  <= pend_in;
      end
   end

   // working registers
   always_ff @(posedge clock) begin
      src_ff       <= src_in;
      last_ff      <= last_in;
      up_ff        <= up_in;
      ins_ff       <= ins_in;
      place_ff     <= place_in;
      val_ff       <= val_in;
      pend_addr_ff <= pend_addr_in;
      rd_ff        <= rd_in;
      st_ff        <= st_in;
   end

   assign req_ready       = (state_ff == S_IDLE);
   assign res_valid       = (state_ff == S_DONE);
   assign res.read_value  = rd_ff;
   assign res.status      = st_ff;
   assign res.entry_count = cnt_x[ils_pkg::CNT_OUT_W-1:0];

endmodule

`default_nettype wire

>>> sv/indexed_list_store.sv
// a rejected item or a delete of the last entry goes straight to the result; a get
// reads the memory first, an insert at the end writes it first, and any other delete
// or insert first shifts the n entries that follow by one slot (n up to CAPACITY - 1)
// throughput: one item at a time, the next accepted at the earliest once the
// previous result has been taken; entries move one per cycle through the memory ports
// reset: synchronous, active high; clears the count and handshake state, not the memory
`timescale 1ns / 1ps
`default_nettype none

`include "indexed_list_store_assert.svh"

module indexed_list_store #(
   parameter int CAPACITY = ils_pkg::CAPACITY_DEF
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [47:0] req_tdata,  // opcode[2:0], position[9:3], item_value[41:10], zero
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [47:0]      rsp_tdata   // read_value[31:0], status[33:32], entry_count[40:34], zero
);

   localparam int AW = $clog2(CAPACITY);

   logic                       res_valid;
   logic                       res_take;
   ils_pkg::res_type           res;
   logic                       mem_wr_en;
   logic [AW-1:0]              mem_wr_addr;
   logic [ils_pkg::DATA_W-1:0] mem_wr_data;
   logic [AW-1:0]              mem_rd_addr;
   logic [ils_pkg::DATA_W-1:0] mem_rd_data;

   logic                       rsp_valid_ff, rsp_valid_in;
   ils_pkg::res_type           rsp_data_ff, rsp_data_in;

   ils_ctrl #(
      .CAPACITY (CAPACITY),
      .AW       (AW)
   ) u_ctrl (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_tvalid),
      .req_ready    (req_tready),
      .req_opcode   (req_tdata[2:0]),
      .req_position (req_tdata[9:3]),
      .req_value    (req_tdata[41:10]),
      .res_valid    (res_valid),
      .res_take     (res_take),
      .res          (res),
      .mem_wr_en    (mem_wr_en),
      .mem_wr_addr  (mem_wr_addr),
      .mem_wr_data  (mem_wr_data),
      .mem_rd_addr  (mem_rd_addr),
      .mem_rd_data  (mem_rd_data)
   );

   ils_ram #(
      .DEPTH (CAPACITY),
      .AW    (AW),
      .DW    (ils_pkg::DATA_W)
   ) u_ram (
      .clock   (clock),
      .wr_en   (mem_wr_en),
      .wr_addr (mem_wr_addr),
      .wr_data (mem_wr_data),
      .rd_addr (mem_rd_addr),
      .rd_data (mem_rd_data)
   );

   // output register
   assign res_take = res_valid && (!rsp_valid_ff || rsp_tready);

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
      if (res_take) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = res;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {7'd0, rsp_data_ff.entry_count, rsp_data_ff.status,
                        rsp_data_ff.read_value};

   // checks
   `ILS_ASSERT_NEXT(a_busy_after_accept, clock, reset, req_tvalid && req_tready,
      !req_tready, "item accepted while a previous one is still in progress")
   `ILS_ASSERT_SAME(a_take_not_ready, clock, reset, res_take, !req_tready,
      "result handed over while the sequencer reports idle")
   `ILS_ASSERT_SAME(a_full_count, clock, reset,
      rsp_tvalid && rsp_tdata[33:32] == ils_pkg::ST_FULL,
      rsp_tdata[40:34] == 7'(CAPACITY), "full status with entry count below capacity")
   `ILS_ASSERT_NEXT(a_take_loads, clock, reset, res_take, rsp_tvalid,
      "result taken but output register empty")

endmodule

`default_nettype wire
